// ===== sv/alvs_pkg.sv =====
// Shared types and constants for the aging LRU victim selector.
// Holds the command codes, the sequencer states and the request and response beats.
// Depends on nothing; every other file of the block but alvs_ram imports it.
package alvs_pkg;

   localparam int LOCK_BITS = 8;

   typedef enum logic [2:0] {
      CMD_INSERT   = 3'd0,
      CMD_REMOVE   = 3'd1,
      CMD_ACCESS   = 3'd2,
      CMD_SET_LOCK = 3'd3,
      CMD_TICK     = 3'd4,
      CMD_SELECT   = 3'd5
   } alvs_cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MODIFY,
      ST_WALK,
      ST_EVICT,
      ST_FINISH
   } alvs_state_type;

   typedef struct packed {
      logic [2:0] command;
      logic [5:0] frame_index;
      logic [7:0] lock_value;
   } alvs_req_type;

   typedef struct packed {
      logic        victim_found;
      logic [5:0]  victim_frame;
      logic [15:0] victim_age;
   } alvs_rsp_type;

endpackage

// ===== sv/alvs_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// Self-contained; used for the frame table of the victim selector.
module alvs_ram #(
   parameter int WIDTH = 26,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/alvs_entry_upd.sv =====
// Per-frame update logic: applies one command to one frame table entry.
// Also judges whether the entry beats the best select candidate so far.
// Depends on alvs_pkg for the command codes and the lock width.
module alvs_entry_upd
   import alvs_pkg::*;
#(
   parameter int AGE_BITS = 16
) (
   input  logic [2:0]                     command,
   input  logic [AGE_BITS+LOCK_BITS+1:0]  entry_i,
   input  logic [LOCK_BITS-1:0]           lock_value,
   input  logic [AGE_BITS-1:0]            best_age,
   output logic [AGE_BITS+LOCK_BITS+1:0]  entry_o,
   output logic                           beats_best
);

   localparam int EW = AGE_BITS + LOCK_BITS + 2;

   logic                 res;
   logic                 acc;
   logic [AGE_BITS-1:0]  age;
   logic [LOCK_BITS-1:0] lock;
   logic                 res_o;
   logic                 acc_o;
   logic [AGE_BITS-1:0]  age_o;
   logic [LOCK_BITS-1:0] lock_o;

   assign res  = entry_i[EW-1];
   assign acc  = entry_i[EW-2];
   assign age  = entry_i[EW-3:LOCK_BITS];
   assign lock = entry_i[LOCK_BITS-1:0];

   always_comb begin
      res_o  = res;
      acc_o  = acc;
      age_o  = age;
      lock_o = lock;
      unique case (command)
         CMD_INSERT: begin
            res_o  = 1'b1;
            acc_o  = 1'b0;
            age_o  = '0;
            lock_o = '0;
         end
         CMD_REMOVE: begin
            res_o  = 1'b0;
            acc_o  = 1'b0;
            age_o  = '0;
            lock_o = '0;
         end
         CMD_ACCESS: begin
            acc_o = acc | res;
         end
         CMD_SET_LOCK: begin
            lock_o = lock_value;
         end
         CMD_TICK: begin
            // Accessed frames restart their age; other resident frames grow, saturating.
            if (res && acc) begin
               acc_o = 1'b0;
               age_o = '0;
            end else if (res && (age != '1)) begin
               age_o = age + AGE_BITS'(1);
            end
         end
         default: begin
         end
      endcase
   end

   assign entry_o    = {res_o, acc_o, age_o, lock_o};
   assign beats_best = res && (lock == '0) && (age > best_age);

endmodule

// ===== sv/aging_lru_victim_select.sv =====
// Aging LRU victim selector: frame table in one RAM, walked by a sequencer.
// Insert, remove, access and set lock with an index in range go through the modify state
// to the finish state, which registers the response beat; tick and select walk the RAM,
// one entry per cycle, and select then passes through the evict state. One command is in
// work at a time; the RAM walk sets the rate. Reset is synchronous: it clears control
// state, then a clearing pass writes every RAM entry to zero with req_stall held high.
module aging_lru_victim_select
   import alvs_pkg::*;
#(
   parameter int NUM_FRAMES = 64,
   parameter int AGE_BITS   = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  alvs_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output alvs_rsp_type rsp_data
);

   localparam int AW = $clog2(NUM_FRAMES);
   localparam int CW = $clog2(NUM_FRAMES + 1);
   localparam int EW = AGE_BITS + LOCK_BITS + 2;
   localparam logic [CW-1:0] CNT_END  = CW'(NUM_FRAMES);
   localparam logic [CW-1:0] CNT_LAST = CW'(NUM_FRAMES - 1);

   // Sequencer and command registers.
   alvs_state_type       state_ff, state_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [2:0]           cmd_ff, cmd_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic [LOCK_BITS-1:0] lock_ff, lock_in;
   logic                 idx_ok_ff, idx_ok_in;

   // Walk pipeline: a read issued in one cycle returns its entry in the next.
   logic                 rd_vld_ff, rd_vld_in;
   logic [AW-1:0]        pend_ff, pend_in;

   // Best select candidate found so far.
   logic                 found_ff, found_in;
   logic [AW-1:0]        bidx_ff, bidx_in;
   logic [AGE_BITS-1:0]  bage_ff, bage_in;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   alvs_rsp_type         rsp_ff, rsp_in;

   // RAM port and update unit wiring.
   logic                 ram_wen;
   logic [AW-1:0]        ram_waddr;
   logic [EW-1:0]        ram_wdata;
   logic [AW-1:0]        ram_raddr;
   logic [EW-1:0]        ram_rdata;
   logic [EW-1:0]        upd_entry;
   logic                 beats_best;

   logic [31:0]          req_idx_wide;
   logic [AW-1:0]        req_addr;
   logic                 req_idx_ok;
   logic [AW-1:0]        cnt_addr;
   logic [31:0]          bidx_wide;
   logic [31:0]          bage_wide;

   assign req_idx_wide = 32'(req_data.frame_index);
   assign req_addr     = req_idx_wide[AW-1:0];
   assign req_idx_ok   = req_idx_wide < 32'(NUM_FRAMES);
   assign cnt_addr     = cnt_ff[AW-1:0];
   assign bidx_wide    = 32'(bidx_ff);
   assign bage_wide    = 32'(bage_ff);

   alvs_ram #(
      .WIDTH (EW),
      .DEPTH (NUM_FRAMES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wen),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   alvs_entry_upd #(
      .AGE_BITS (AGE_BITS)
   ) u_upd (
      .command    (cmd_ff),
      .entry_i    (ram_rdata),
      .lock_value (lock_ff),
      .best_age   (bage_ff),
      .entry_o    (upd_entry),
      .beats_best (beats_best)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff    <= cmd_in;
      idx_ff    <= idx_in;
      lock_ff   <= lock_in;
      idx_ok_ff <= idx_ok_in;
      pend_ff   <= pend_in;
      found_ff  <= found_in;
      bidx_ff   <= bidx_in;
      bage_ff   <= bage_in;
      rsp_ff    <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      lock_in      = lock_ff;
      idx_ok_in    = idx_ok_ff;
      rd_vld_in    = 1'b0;
      pend_in      = pend_ff;
      found_in     = found_ff;
      bidx_in      = bidx_ff;
      bage_in      = bage_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      ram_wen      = 1'b0;
      ram_waddr    = pend_ff;
      ram_wdata    = upd_entry;
      ram_raddr    = cnt_addr;
      req_stall    = (state_ff != ST_IDLE);

      unique case (state_ff)
         ST_CLEAR: begin
            // Zero one entry per cycle after reset.
            ram_wen   = 1'b1;
            ram_waddr = cnt_addr;
            ram_wdata = '0;
            if (cnt_ff == CNT_LAST) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         ST_IDLE: begin
            // The addressed entry is read speculatively so it is ready next cycle.
            ram_raddr = req_addr;
            if (req_valid) begin
               cmd_in    = req_data.command;
               idx_in    = req_addr;
               lock_in   = req_data.lock_value;
               idx_ok_in = req_idx_ok;
               found_in  = 1'b0;
               bidx_in   = '0;
               bage_in   = '0;
               cnt_in    = '0;
               unique case (req_data.command)
                  CMD_INSERT, CMD_REMOVE, CMD_ACCESS, CMD_SET_LOCK: begin
                     state_in = req_idx_ok ? ST_MODIFY : ST_FINISH;
                  end
                  CMD_TICK, CMD_SELECT: begin
                     state_in = ST_WALK;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_MODIFY: begin
            ram_wen   = idx_ok_ff;
            ram_waddr = idx_ff;
            state_in  = ST_FINISH;
         end
         ST_WALK: begin
            // Issue the read for entry cnt while handling the entry read last cycle.
            if (cnt_ff != CNT_END) begin
               cnt_in    = cnt_ff + CW'(1);
               rd_vld_in = 1'b1;
               pend_in   = cnt_addr;
            end
            if (rd_vld_ff) begin
               if (cmd_ff == CMD_TICK) begin
                  ram_wen = 1'b1;
               end
               if ((cmd_ff == CMD_SELECT) && beats_best) begin
                  found_in = 1'b1;
                  bidx_in  = pend_ff;
                  bage_in  = ram_rdata[EW-3:LOCK_BITS];
               end
            end
            if ((cnt_ff == CNT_END) && rd_vld_ff) begin
               state_in = (cmd_ff == CMD_SELECT) ? ST_EVICT : ST_FINISH;
            end
         end
         ST_EVICT: begin
            // The victim had lock count zero, so an all-zero entry is exactly its new state.
            ram_wen   = found_ff;
            ram_waddr = bidx_ff;
            ram_wdata = '0;
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in        = 1'b1;
               rsp_in.victim_found = found_ff;
               rsp_in.victim_frame = bidx_wide[5:0];
               rsp_in.victim_age   = bage_wide[15:0];
               state_in            = ST_IDLE;
            end
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A select walk only reads the table.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && cmd_ff == CMD_SELECT) |-> !ram_wen)
      else $error("table written during select walk");

   // The walk counter never passes the table size.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (cnt_ff <= CNT_END))
      else $error("walk counter overran");

   // A found victim always has a nonzero age.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVICT && found_ff) |-> (bage_ff != '0))
      else $error("victim with zero age");

   // Reset always starts the clearing pass.
   assert property (@(posedge clock)
      reset |=> (state_ff == ST_CLEAR && cnt_ff == '0))
      else $error("reset did not start clearing pass");

   // A response beat is loaded only from the finish state.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff && rsp_valid_in) |-> (state_ff == ST_FINISH))
      else $error("response loaded outside finish");

endmodule

// ===== test/alvs_checker.sv =====
// Checker for the aging LRU victim selector: watches both channels, keeps its own frame table,
// predicts one response beat per accepted command and compares field by field.
// Depends on alvs_pkg for the command codes and the beat types.
`timescale 1ns / 100ps

module alvs_checker
   import alvs_pkg::*;
#(
   parameter int NUM_FRAMES = 64,
   parameter int AGE_BITS   = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  alvs_req_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  alvs_rsp_type rsp_data,
   output int           mismatch_count,
   output int           pending_count
);

   logic                  frame_resident [NUM_FRAMES];
   logic                  frame_accessed [NUM_FRAMES];
   logic [AGE_BITS-1:0]   frame_age      [NUM_FRAMES];
   logic [LOCK_BITS-1:0]  frame_lock     [NUM_FRAMES];

   alvs_rsp_type expected_victims [$];

   task automatic clear_table();
      for (int f = 0; f < NUM_FRAMES; f++) begin
         frame_resident[f] = 1'b0;
         frame_accessed[f] = 1'b0;
         frame_age[f]      = '0;
         frame_lock[f]     = '0;
      end
   endtask

   // Applies one command to the frame table and returns the victim it evicts, if any.
   function automatic alvs_rsp_type apply_command(alvs_req_type beat);
      alvs_rsp_type        victim;
      int                  idx;
      int                  best;
      logic [AGE_BITS-1:0] best_age;
      logic                found;
      victim   = '0;
      idx      = int'(beat.frame_index);
      best     = 0;
      best_age = '0;
      found    = 1'b0;
      case (beat.command)
         CMD_INSERT, CMD_REMOVE: begin
            if (idx < NUM_FRAMES) begin
               frame_resident[idx] = (beat.command == CMD_INSERT);
               frame_accessed[idx] = 1'b0;
               frame_age[idx]      = '0;
               frame_lock[idx]     = '0;
            end
         end
         CMD_ACCESS: begin
            if (idx < NUM_FRAMES && frame_resident[idx])
               frame_accessed[idx] = 1'b1;
         end
         CMD_SET_LOCK: begin
            if (idx < NUM_FRAMES)
               frame_lock[idx] = beat.lock_value;
         end
         CMD_TICK: begin
            for (int f = 0; f < NUM_FRAMES; f++) begin
               if (frame_resident[f]) begin
                  if (frame_accessed[f]) begin
                     frame_accessed[f] = 1'b0;
                     frame_age[f]      = '0;
                  end else if (frame_age[f] != '1) begin
                     frame_age[f] = frame_age[f] + 1'b1;
                  end
               end
            end
         end
         CMD_SELECT: begin
            for (int f = 0; f < NUM_FRAMES; f++) begin
               if (frame_resident[f] && frame_lock[f] == '0 && frame_age[f] > best_age) begin
                  best_age = frame_age[f];
                  best     = f;
                  found    = 1'b1;
               end
            end
            if (found) begin
               frame_resident[best] = 1'b0;
               frame_accessed[best] = 1'b0;
               frame_age[best]      = '0;
               victim.victim_found  = 1'b1;
               victim.victim_frame  = 6'(best);
               victim.victim_age    = 16'(best_age);
            end
         end
         default: begin
         end
      endcase
      return victim;
   endfunction

   // The counts start at zero as two-state variables; the table is cleared while reset is high.
   always @(posedge clock) begin
      alvs_rsp_type want;
      if (reset) begin
         clear_table();
         expected_victims.delete();
      end else begin
         if (req_valid && !req_stall)
            expected_victims.push_back(apply_command(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_victims.size() == 0) begin
               $error("response beat with nothing expected: %h", rsp_data);
               mismatch_count++;
            end else begin
               want = expected_victims.pop_front();
               if (rsp_data.victim_found !== want.victim_found) begin
                  $error("victim_found: expected %0d, got %0d",
                         want.victim_found, rsp_data.victim_found);
                  mismatch_count++;
               end
               if (rsp_data.victim_frame !== want.victim_frame) begin
                  $error("victim_frame: expected %0d, got %0d",
                         want.victim_frame, rsp_data.victim_frame);
                  mismatch_count++;
               end
               if (rsp_data.victim_age !== want.victim_age) begin
                  $error("victim_age: expected %0d, got %0d",
                         want.victim_age, rsp_data.victim_age);
                  mismatch_count++;
               end
            end
         end
      end
      pending_count <= expected_victims.size();
   end

endmodule

// ===== test/tb.sv =====
// Top of the aging LRU victim selector testbench: clock, reset, command stimulus, response
// stall pattern and the verdict. Depends on alvs_pkg, aging_lru_victim_select and alvs_checker.
`timescale 1ns / 100ps

module tb;
   import alvs_pkg::*;

   localparam int NUM_FRAMES   = 64;
   localparam int AGE_BITS     = 16;
   localparam int RANDOM_BEATS = 1300;
   // Length of the single long response hold-off, and the response count that triggers it.
   localparam int HOLD_CYCLES  = 400;
   localparam int HOLD_AFTER   = 300;
   // The package names only the six defined commands; these two codes are spare.
   localparam logic [2:0] CMD_SPARE_LO = 3'd6;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   alvs_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   alvs_rsp_type rsp_data;

   int mismatch_count;
   int pending_count;
   int responses_taken = 0;
   int burst_left      = 0;

   aging_lru_victim_select #(
      .NUM_FRAMES (NUM_FRAMES),
      .AGE_BITS   (AGE_BITS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   alvs_checker #(
      .NUM_FRAMES (NUM_FRAMES),
      .AGE_BITS   (AGE_BITS)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // The limit leaves ample room for the slowest correct run.
   initial begin
      #3000000;
      $display("end of test: mismatches");
      $finish;
   end

   // The receiver tracks how many response beats it has taken, to time its long hold-off.
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall)
         responses_taken <= responses_taken + 1;
   end

   function automatic alvs_req_type make_beat(logic [2:0] command, logic [5:0] frame_index,
                                              logic [7:0] lock_value);
      alvs_req_type beat;
      beat.command     = command;
      beat.frame_index = frame_index;
      beat.lock_value  = lock_value;
      return beat;
   endfunction

   // Offers one command beat and returns once it has been accepted. The sender works in
   // bursts: when a burst runs out it idles for a random gap, which is often zero so that
   // long back-to-back stretches occur, and sometimes longer than a full table walk so that
   // new beats arrive at every phase of the block's work.
   task automatic send_beat(alvs_req_type beat);
      int gap;
      if (burst_left == 0) begin
         case ($urandom_range(0, 3))
            0:       gap = 0;
            1:       gap = $urandom_range(1, 4);
            2:       gap = $urandom_range(1, 20);
            default: gap = $urandom_range(20, 90);
         endcase
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
      burst_left--;
   endtask

   // Random commands are weighted toward the ones that build up a table worth selecting
   // from: inserts, accesses and ticks to age frames, and frequent selects. Most frame
   // indexes come from a small pool so that commands keep meeting resident frames.
   function automatic alvs_req_type random_beat();
      int         pick;
      logic [2:0] command;
      logic [5:0] frame_index;
      logic [7:0] lock_value;
      pick = $urandom_range(0, 99);
      if (pick < 14)
         command = CMD_INSERT;
      else if (pick < 18)
         command = CMD_REMOVE;
      else if (pick < 38)
         command = CMD_ACCESS;
      else if (pick < 46)
         command = CMD_SET_LOCK;
      else if (pick < 72)
         command = CMD_TICK;
      else if (pick < 97)
         command = CMD_SELECT;
      else
         command = ($urandom_range(0, 1) == 0) ? CMD_SPARE_LO : CMD_SPARE_HI;
      if ($urandom_range(0, 4) == 0)
         frame_index = 6'($urandom_range(0, 63));
      else
         frame_index = 6'($urandom_range(0, 11));
      // Lock writes mostly release a frame, or else locks would pile up and starve selects.
      // Every other command carries random noise in the lock field.
      if (command == CMD_SET_LOCK && $urandom_range(0, 9) < 6)
         lock_value = '0;
      else
         lock_value = 8'($urandom_range(0, 255));
      return make_beat(command, frame_index, lock_value);
   endfunction

   // Receiver: stalls on a pattern of its own, switching between modes that range from never
   // stalling to stalling most cycles. Once, after a few hundred responses, it holds off for
   // a long stretch while the sender keeps offering, so the block backs up and stalls input.
   initial begin
      int  hold_left;
      int  mode;
      int  mode_left;
      bit  hold_done;
      hold_left = 0;
      mode      = 0;
      mode_left = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && responses_taken >= HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(8, 150);
            end
            mode_left--;
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= ($urandom_range(0, 1) == 0);
               default: rsp_stall <= ($urandom_range(0, 4) != 0);
            endcase
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. A select on the empty table finds nothing. Frames 0, 63, 21 and 42
      // cover both values of every index bit.
      send_beat(make_beat(CMD_SELECT,   6'd0,  8'd0));
      send_beat(make_beat(CMD_INSERT,   6'd0,  8'd0));
      send_beat(make_beat(CMD_INSERT,   6'd63, 8'd255));
      send_beat(make_beat(CMD_INSERT,   6'd21, 8'd0));
      send_beat(make_beat(CMD_INSERT,   6'd42, 8'd0));
      send_beat(make_beat(CMD_TICK,     6'd0,  8'd0));
      // An access to a resident frame, then one to a frame that is not resident and is ignored.
      send_beat(make_beat(CMD_ACCESS,   6'd63, 8'd0));
      send_beat(make_beat(CMD_ACCESS,   6'd5,  8'd0));
      // Lock 0 at the largest count and 42 with alternating bits; the tick then clears 63.
      send_beat(make_beat(CMD_SET_LOCK, 6'd0,  8'd255));
      send_beat(make_beat(CMD_SET_LOCK, 6'd42, 8'hAA));
      send_beat(make_beat(CMD_TICK,     6'd0,  8'd0));
      // Frames 0 and 42 are locked, so 21 goes first; releasing 42 makes it the next victim.
      send_beat(make_beat(CMD_SELECT,   6'd0,  8'd0));
      send_beat(make_beat(CMD_SET_LOCK, 6'd42, 8'd0));
      send_beat(make_beat(CMD_SELECT,   6'd0,  8'd0));
      // Removing a locked resident frame also drops its lock; insert brings it back fresh.
      send_beat(make_beat(CMD_REMOVE,   6'd0,  8'd0));
      send_beat(make_beat(CMD_INSERT,   6'd0,  8'd0));
      // A lock written to a frame that is not resident sticks until the insert clears it.
      send_beat(make_beat(CMD_SET_LOCK, 6'd30, 8'h55));
      send_beat(make_beat(CMD_INSERT,   6'd30, 8'd0));
      send_beat(make_beat(CMD_TICK,     6'd0,  8'd0));
      send_beat(make_beat(CMD_TICK,     6'd0,  8'd0));
      // Inserting a resident frame restarts its age; 0 and 30 then tie and the lower wins.
      send_beat(make_beat(CMD_INSERT,   6'd63, 8'd0));
      send_beat(make_beat(CMD_SELECT,   6'd0,  8'd0));
      // The spare codes change nothing and answer with an empty beat.
      send_beat(make_beat(CMD_SPARE_LO, 6'd63, 8'd255));
      send_beat(make_beat(CMD_SPARE_HI, 6'd21, 8'h55));
      send_beat(make_beat(CMD_SELECT,   6'd0,  8'd0));
      // Only frame 63 is left, resident but with age zero, so nothing is eligible.
      send_beat(make_beat(CMD_SELECT,   6'd0,  8'd0));

      for (int n = 0; n < RANDOM_BEATS; n++)
         send_beat(random_beat());

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      // Leave a full walk's worth of cycles for any stray response beat to show up.
      repeat (NUM_FRAMES + 16) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
